>>> rtl/sgc_pkg.sv
// Package for the shading gain calculator: widths, register indexes, gain codes
// and the record that travels down the division pipeline. No dependencies.
package sgc_pkg;

    localparam int SGC_DATA_W          = 16;
    localparam int SGC_CFG_IDX_W       = 2;
    localparam int SGC_STEPS_PER_STAGE = 2;

    localparam logic [SGC_CFG_IDX_W-1:0] SGC_REG_TARGET = 2'd0;
    localparam logic [SGC_CFG_IDX_W-1:0] SGC_REG_MODE   = 2'd1;

    localparam logic SGC_MODE_GAIN4 = 1'b0;
    localparam logic SGC_MODE_GAIN8 = 1'b1;

    localparam logic [4:0] SGC_SHIFT_GAIN4 = 5'd14;
    localparam logic [4:0] SGC_SHIFT_GAIN8 = 5'd13;

    typedef struct packed {
        logic [SGC_DATA_W-1:0] rem;
        logic [SGC_DATA_W-1:0] low;
        logic [SGC_DATA_W-1:0] den;
        logic                  sat;
        logic                  last;
    } t_sgc_stage;

endpackage

>>> rtl/sgc_front.sv
// Input stage of the shading gain calculator: forms divisor and dividend,
// detects saturation and registers the first pipeline record. Uses sgc_pkg.
module sgc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sgc_pkg::SGC_DATA_W-1:0] i_dark_sample,
    input  logic [sgc_pkg::SGC_DATA_W-1:0] i_light_sample,
    input  logic                          i_last_sample,
    input  logic [sgc_pkg::SGC_DATA_W-1:0] i_target_level,
    input  logic                          i_gain_mode,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sgc_pkg::t_sgc_stage           o_data
);
    import sgc_pkg::*;

    logic                    r_valid;
    t_sgc_stage              r_data;
    t_sgc_stage              n_data;
    logic [SGC_DATA_W-1:0]   tgt;
    logic [SGC_DATA_W:0]     diff;
    logic [2*SGC_DATA_W-1:0] num;

    always_comb begin
        tgt  = (i_target_level == '0) ? SGC_DATA_W'(1) : i_target_level;
        diff = {1'b0, i_light_sample} - {1'b0, i_dark_sample};
        if (!diff[SGC_DATA_W] && (diff[SGC_DATA_W-1:0] != '0)) begin
            n_data.den = diff[SGC_DATA_W-1:0];
        end else begin
            n_data.den = tgt;
        end
        num = {{SGC_DATA_W{1'b0}}, tgt}
              << ((i_gain_mode == SGC_MODE_GAIN8) ? SGC_SHIFT_GAIN8 : SGC_SHIFT_GAIN4);
        n_data.rem  = num[2*SGC_DATA_W-1:SGC_DATA_W];
        n_data.low  = num[SGC_DATA_W-1:0];
        n_data.sat  = (num[2*SGC_DATA_W-1:SGC_DATA_W] >= n_data.den);
        n_data.last = i_last_sample;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef NO_ASSERTIONS
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.den != '0))
        else $error("divisor of zero entered the pipeline");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.sat) |-> (r_data.rem < r_data.den))
        else $error("unsaturated item starts with remainder not below divisor");
`endif

endmodule

>>> rtl/sgc_div_stage.sv
// One stage of the restoring divider: STEPS quotient bits per register stage,
// with its own valid bit and stall handling. Uses sgc_pkg.
module sgc_div_stage #(
    parameter int STEPS = sgc_pkg::SGC_STEPS_PER_STAGE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sgc_pkg::t_sgc_stage i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sgc_pkg::t_sgc_stage o_data
);
    import sgc_pkg::*;

    logic                  r_valid;
    t_sgc_stage            r_data;
    t_sgc_stage            n_data;
    logic [SGC_DATA_W:0]   trial;
    logic [SGC_DATA_W:0]   diff;

    always_comb begin
        n_data = i_data;
        trial  = '0;
        diff   = '0;
        for (int s = 0; s < STEPS; s++) begin
            trial = {n_data.rem, n_data.low[SGC_DATA_W-1]};
            diff  = trial - {1'b0, n_data.den};
            if (!diff[SGC_DATA_W]) begin
                n_data.rem = diff[SGC_DATA_W-1:0];
                n_data.low = {n_data.low[SGC_DATA_W-2:0], 1'b1};
            end else begin
                n_data.rem = trial[SGC_DATA_W-1:0];
                n_data.low = {n_data.low[SGC_DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef NO_ASSERTIONS
    a_rem_kept_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.sat) |-> (r_data.rem < r_data.den))
        else $error("partial remainder reached the divisor");
`endif

endmodule

>>> rtl/shading_gain_calculator.sv
// Top level of the shading gain calculator: configuration registers, input
// stage and the chain of divider stages. Uses sgc_pkg, sgc_front, sgc_div_stage.
//
// The block takes one dark/light sample pair per clock cycle and delivers one
// coefficient per cycle while the output is not stalled; the input stage and
// the restoring divider, cut into register stages of DIV_STEPS quotient bits
// each, register each item in turn. A stall at the output fills the pipeline
// bubbles before input ready drops. Configuration writes are always accepted
// and take effect on the next item.
module shading_gain_calculator #(
    parameter int DIV_STEPS = sgc_pkg::SGC_STEPS_PER_STAGE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sgc_pkg::SGC_DATA_W-1:0]    i_dark_sample,
    input  logic [sgc_pkg::SGC_DATA_W-1:0]    i_light_sample,
    input  logic                              i_last_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sgc_pkg::SGC_DATA_W-1:0]    o_coefficient,
    output logic                              o_saturated,
    output logic                              o_last_coefficient,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sgc_pkg::SGC_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sgc_pkg::SGC_DATA_W-1:0]    i_cfg_data
);
    import sgc_pkg::*;

    localparam int NUM_STAGES = SGC_DATA_W / DIV_STEPS;

    logic [SGC_DATA_W-1:0] r_target_level;
    logic                  r_gain_mode;

    logic       stg_valid [NUM_STAGES+1];
    logic       stg_ready [NUM_STAGES+1];
    t_sgc_stage stg_data  [NUM_STAGES+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_level <= SGC_DATA_W'(1);
            r_gain_mode    <= SGC_MODE_GAIN4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                SGC_REG_TARGET: r_target_level <= i_cfg_data;
                SGC_REG_MODE:   r_gain_mode    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    sgc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_dark_sample  (i_dark_sample),
        .i_light_sample (i_light_sample),
        .i_last_sample  (i_last_sample),
        .i_target_level (r_target_level),
        .i_gain_mode    (r_gain_mode),
        .o_valid        (stg_valid[0]),
        .i_ready        (stg_ready[0]),
        .o_data         (stg_data[0])
    );

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_div
        sgc_div_stage #(
            .STEPS (DIV_STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    assign stg_ready[NUM_STAGES] = i_ready;
    assign o_valid               = stg_valid[NUM_STAGES];
    assign o_coefficient         = stg_data[NUM_STAGES].sat ? '1 : stg_data[NUM_STAGES].low;
    assign o_saturated           = stg_data[NUM_STAGES].sat;
    assign o_last_coefficient    = stg_data[NUM_STAGES].last;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while the output side was free");
`endif

endmodule
